### rtl/htfa_pkg.sv
// Shared definitions for the hole table fit allocator.
// Fit policy codes and fixed port widths; no dependencies.
`timescale 1ns / 1ps

package htfa_pkg;

  // fixed widths of the external fields
  localparam int IDX_PORT_W = 11;
  localparam int AMT_PORT_W = 16;
  localparam int POL_W      = 2;

  typedef logic [POL_W-1:0] policy_t;

  // fit policy codes
  localparam policy_t POL_FIRST = 2'd0;
  localparam policy_t POL_NEXT  = 2'd1;
  localparam policy_t POL_BEST  = 2'd2;
  localparam policy_t POL_WORST = 2'd3;

endpackage

### rtl/htfa_select.sv
// Candidate selector for the hole table scan: keeps the chosen hole.
// Depends on htfa_pkg for the fit policy codes.
`timescale 1ns / 1ps

module htfa_select import htfa_pkg::*; #(
  parameter int IDXW      = 11,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 clr,
  input  policy_t              policy,
  input  logic                 vld,
  input  logic [SIZE_BITS-1:0] data,
  input  logic [IDXW-1:0]      tag,
  input  logic [SIZE_BITS-1:0] amt,
  output logic                 found,
  output logic [IDXW-1:0]      pick,
  output logic [SIZE_BITS-1:0] best
);

  logic                 found_r, found_nxt;
  logic [IDXW-1:0]      pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic                 fits;
  logic                 take;

  // does this entry beat the current candidate
  always_comb begin
    fits = (data >= amt);
    case (policy)
      POL_FIRST, POL_NEXT: take = fits && !found_r;
      POL_BEST:            take = fits && (!found_r || (data <= best_r));
      POL_WORST:           take = fits && (!found_r || (data >= best_r));
      default:             take = 1'b0;
    endcase
  end

  // candidate update
  always_comb begin
    found_nxt = found_r;
    pick_nxt  = pick_r;
    best_nxt  = best_r;
    if (clr) begin
      found_nxt = 1'b0;
    end else if (vld && take) begin
      found_nxt = 1'b1;
      pick_nxt  = tag;
      best_nxt  = data;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    pick_r  <= pick_nxt;
    best_r  <= best_nxt;
  end

  assign found = found_r;
  assign pick  = pick_r;
  assign best  = best_r;

endmodule

### rtl/hole_table_fit_allocator.sv
// Top level of the hole table fit allocator: hole memory, scan sequencer.
// Depends on htfa_pkg and htfa_select.
`timescale 1ns / 1ps

// Usage:
//   Input: an item transfers at a clock edge with start high and busy low.
//   A load item (in_kind 0) writes in_amount into entry in_entry_index in
//   the accept cycle; it gives no result and busy stays low, so loads can
//   follow back to back. An index at or beyond ENTRIES is dropped.
//   An allocate item (in_kind 1) reads every hole once through the single
//   read port of the hole memory, one entry per cycle, starting at entry 0
//   or, for next fit, at the last next-fit grant. busy stays high through
//   the scan and the done step that writes back the shrunk hole, and the
//   result strobes after the done step; the memory scan sets how long.
//   Output: out_strobe is high for one cycle with granted, hole_index and
//   remaining. The receiver takes it in that cycle; nothing holds it off.
//   Config: cfg_we writes cfg_wdata into the fit policy register; write it
//   only while busy is low and no result is pending.
//   Reset: rst_n low (synchronous) sets first fit and next-fit start 0,
//   then a clearing pass zeroes every entry of the hole table with busy
//   high.

module hole_table_fit_allocator import htfa_pkg::*; #(
  parameter int ENTRIES   = 2048,
  parameter int SIZE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [IDX_PORT_W-1:0] in_entry_index,
  input  logic [AMT_PORT_W-1:0] in_amount,
  output logic                  out_strobe,
  output logic                  out_granted,
  output logic [IDX_PORT_W-1:0] out_hole_index,
  output logic [AMT_PORT_W-1:0] out_remaining,
  input  logic                  cfg_we,
  input  logic [POL_W-1:0]      cfg_wdata
);

  localparam int          IDXW      = $clog2(ENTRIES);
  localparam logic [31:0] ENTRIES_W = 32'(ENTRIES);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  policy_t              policy_r;
  logic [IDX_PORT_W-1:0] nfs_r;
  logic [IDXW-1:0]      rd_addr_r, rd_addr_nxt;
  logic [IDXW:0]        rd_cnt_r, rd_cnt_nxt;
  logic                 issue_v_r;
  logic [IDXW-1:0]      tag_r;
  logic [SIZE_BITS-1:0] amt_r;
  logic                 out_strobe_r;
  logic                 out_granted_r;
  logic [IDX_PORT_W-1:0] out_hole_index_r;
  logic [AMT_PORT_W-1:0] out_remaining_r;

  logic [SIZE_BITS-1:0] mem [ENTRIES];
  logic [SIZE_BITS-1:0] rdata_r;

  logic                 accept;
  logic                 in_range;
  logic                 rd_en;
  logic                 scan_last;
  logic                 mem_we;
  logic [IDXW-1:0]      mem_wa;
  logic [SIZE_BITS-1:0] mem_wd;
  logic [IDXW-1:0]      addr_inc;
  logic                 sel_found;
  logic [IDXW-1:0]      sel_pick;
  logic [SIZE_BITS-1:0] sel_best;
  logic [SIZE_BITS-1:0] shrunk;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign in_range  = ({{(32 - IDX_PORT_W){1'b0}}, in_entry_index} < ENTRIES_W);
  assign rd_en     = (state_r == ST_SCAN) && (rd_cnt_r != (IDXW + 1)'(ENTRIES));
  assign scan_last = (rd_cnt_r == (IDXW + 1)'(ENTRIES)) && !issue_v_r;
  assign addr_inc  = (rd_addr_r == IDXW'(ENTRIES - 1)) ? '0 : rd_addr_r + 1'b1;
  assign shrunk    = sel_best - amt_r;

  // hole memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_addr_r;
    mem_wd = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_we = accept && !in_kind && in_range;
        mem_wa = IDXW'(in_entry_index);
        mem_wd = SIZE_BITS'(in_amount);
      end
      ST_DONE: begin
        mem_we = sel_found;
        mem_wa = sel_pick;
        mem_wd = shrunk;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // hole memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr_r];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt   = state_r;
    rd_addr_nxt = rd_addr_r;
    rd_cnt_nxt  = rd_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        rd_addr_nxt = addr_inc;
        if (rd_addr_r == IDXW'(ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_kind) begin
          state_nxt   = ST_SCAN;
          rd_cnt_nxt  = '0;
          rd_addr_nxt = (policy_r == POL_NEXT) ? IDXW'(nfs_r) : '0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_addr_nxt = addr_inc;
          rd_cnt_nxt  = rd_cnt_r + 1'b1;
        end
        if (scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      rd_addr_r    <= '0;
      rd_cnt_r     <= '0;
      issue_v_r    <= 1'b0;
      policy_r     <= POL_FIRST;
      nfs_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_addr_r    <= rd_addr_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      issue_v_r    <= rd_en;
      out_strobe_r <= (state_r == ST_DONE);
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
      if ((state_r == ST_DONE) && sel_found && (policy_r == POL_NEXT)) begin
        nfs_r <= IDX_PORT_W'(sel_pick);
      end
    end
  end

  // payload registers: read tag, request size, result fields
  always_ff @(posedge clk) begin
    tag_r <= rd_addr_r;
    if (accept && in_kind) begin
      amt_r <= SIZE_BITS'(in_amount);
    end
    if (state_r == ST_DONE) begin
      out_granted_r    <= sel_found;
      out_hole_index_r <= sel_found ? IDX_PORT_W'(sel_pick) : '0;
      out_remaining_r  <= sel_found ? AMT_PORT_W'(shrunk) : '0;
    end
  end

  // candidate tracking over the scan
  htfa_select #(
    .IDXW      (IDXW),
    .SIZE_BITS (SIZE_BITS)
  ) u_select (
    .clk    (clk),
    .clr    (accept && in_kind),
    .policy (policy_r),
    .vld    (issue_v_r),
    .data   (rdata_r),
    .tag    (tag_r),
    .amt    (amt_r),
    .found  (sel_found),
    .pick   (sel_pick),
    .best   (sel_best)
  );

  assign out_strobe     = out_strobe_r;
  assign out_granted    = out_granted_r;
  assign out_hole_index = out_hole_index_r;
  assign out_remaining  = out_remaining_r;

endmodule
